/* rtl/rwf_pkg.sv */
// Package for the replay window filter: sizes, verdict and register codes,
// and the control bundle that drives each storage cell. No dependencies.
package rwf_pkg;

  localparam int unsigned RWF_DEPTH = 64;
  localparam int unsigned ID_W      = 256;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned MAXE_W    = 7;
  localparam int unsigned VERDICT_W = 2;

  localparam logic [VERDICT_W-1:0] VERDICT_OK        = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_OLD   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_NEW   = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TTL         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW        = 2'd2;

  localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 7'd64;

  typedef struct packed {
    logic shift;  // take the younger neighbour's entry
    logic load;   // store the incoming id and time
  } cell_ctrl_t;

endpackage

/* rtl/replay_window_filter.sv */
// Top level of the replay window filter: configuration registers, control
// sequencer and the row of rwf_cell storage cells. Depends on rwf_pkg.
//
// Usage: an item arrives on the in_ channel (valid/ready) with a 256-bit id,
// its creation time and the current time. One verdict per item leaves on the
// out_ channel (valid/ready): ok, too old, too far in future or duplicate.
// Configuration (max entries, ttl, skew) is written through the cfg_ channel,
// which is always ready; writes to an unused index are ignored.
// Held entries sit in age order along the cell row, the oldest in cell 0.
// Dropping the oldest entry shifts the whole row by one cell per cycle.
// For an item with a valid id that passes the skew check, the sequencer
// steps through check, prune (once per entry pruned), match, evict (once per
// entry evicted) and done, and the verdict is then registered; a duplicate
// goes from match straight to done. An item without a valid id, or one
// rejected by the skew check, goes from check straight to done.
// One item is worked on at a time: in_ready rises together with the verdict,
// and no new item is taken while the last one is still being worked on.
// If the receiver stalls, the verdict is held and the sequencer waits with
// the next verdict until the output register is free.
// Reset empties the store and restores max entries 64, ttl 0 and skew 0;
// the cell contents themselves are not cleared.
module replay_window_filter
  import rwf_pkg::*;
#(
  parameter int unsigned DEPTH = RWF_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 id_valid_i,
  input  logic [63:0]          id_word0_i,
  input  logic [63:0]          id_word1_i,
  input  logic [63:0]          id_word2_i,
  input  logic [63:0]          id_word3_i,
  input  logic signed [TIME_W-1:0] created_time_i,
  input  logic signed [TIME_W-1:0] now_time_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [VERDICT_W-1:0] verdict_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PRUNE,
    ST_MATCH,
    ST_EVICT,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [MAXE_W-1:0]    max_entries_q;
  logic [31:0]          ttl_q;
  logic [31:0]          skew_q;
  logic [CW-1:0]        count_q;
  logic [VERDICT_W-1:0] result_q;
  logic                 out_valid_q;
  logic [VERDICT_W-1:0] verdict_q;

  logic                 id_valid_q;
  logic [ID_W-1:0]      key_id_q;
  logic [TIME_W-1:0]    created_q;
  logic [TIME_W-1:0]    now_q;

  logic [ID_W-1:0]      cell_id   [DEPTH];
  logic [TIME_W-1:0]    cell_time [DEPTH];
  logic [DEPTH-1:0]     cell_match;
  cell_ctrl_t           cell_ctrl [DEPTH];

  logic [CW-1:0]        limit;
  logic                 skew_on;
  logic [TIME_W:0]      age_created;
  logic [TIME_W:0]      lead_created;
  logic                 too_old;
  logic                 too_new;
  logic [TIME_W:0]      age_oldest;
  logic                 expired;
  logic                 any_match;
  logic                 shift_en;
  logic                 load_en;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  // Effective limit: zero acts as one, anything above the depth as the depth.
  always_comb begin
    if (max_entries_q == '0) begin
      limit = CW'(1);
    end else if (32'(max_entries_q) > 32'(DEPTH)) begin
      limit = CW'(DEPTH);
    end else begin
      limit = CW'(max_entries_q);
    end
  end

  // Time differences are taken at 65 bits so that they never wrap.
  assign skew_on      = (skew_q != '0) && !created_q[TIME_W-1] && (created_q != '0);
  assign age_created  = {now_q[TIME_W-1], now_q} - {created_q[TIME_W-1], created_q};
  assign lead_created = {created_q[TIME_W-1], created_q} - {now_q[TIME_W-1], now_q};
  assign too_old      = !age_created[TIME_W] && (age_created > {33'd0, skew_q});
  assign too_new      = !lead_created[TIME_W] && (lead_created > {33'd0, skew_q});

  assign age_oldest = {now_q[TIME_W-1], now_q} - {cell_time[0][TIME_W-1], cell_time[0]};
  assign expired    = (ttl_q != '0) && (count_q != '0) && !age_oldest[TIME_W] &&
                      (age_oldest > {33'd0, ttl_q});

  always_comb begin
    any_match = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      if (cell_match[k] && (CW'(k) < count_q)) begin
        any_match = 1'b1;
      end
    end
  end

  assign shift_en = ((state_q == ST_PRUNE) && expired) ||
                    ((state_q == ST_EVICT) && (count_q >= limit));
  assign load_en  = (state_q == ST_EVICT) && (count_q < limit);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ID_W-1:0]   next_id;
    logic [TIME_W-1:0] next_time;

    if (k < DEPTH - 1) begin : g_inner
      assign next_id   = cell_id[k+1];
      assign next_time = cell_time[k+1];
    end else begin : g_last
      assign next_id   = cell_id[k];
      assign next_time = cell_time[k];
    end

    assign cell_ctrl[k].shift = shift_en;
    assign cell_ctrl[k].load  = load_en && (count_q == CW'(k));

    rwf_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[k]),
      .next_id_i   (next_id),
      .next_time_i (next_time),
      .key_id_i    (key_id_q),
      .key_time_i  (now_q),
      .id_o        (cell_id[k]),
      .time_o      (cell_time[k]),
      .match_o     (cell_match[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      id_valid_q <= id_valid_i;
      key_id_q   <= {id_word3_i, id_word2_i, id_word1_i, id_word0_i};
      created_q  <= created_time_i;
      now_q      <= now_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      max_entries_q <= MAX_ENTRIES_RST;
      ttl_q         <= '0;
      skew_q        <= '0;
      count_q       <= '0;
      result_q      <= VERDICT_OK;
      out_valid_q   <= 1'b0;
      verdict_q     <= VERDICT_OK;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MAX_ENTRIES: max_entries_q <= cfg_data_i[MAXE_W-1:0];
          REG_TTL:         ttl_q         <= cfg_data_i;
          REG_SKEW:        skew_q        <= cfg_data_i;
          default:         ;
        endcase
      end

      // In the done state the output register is handled by the sequencer.
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!id_valid_q) begin
            result_q <= VERDICT_OK;
            state_q  <= ST_DONE;
          end else if (skew_on && too_old) begin
            result_q <= VERDICT_TOO_OLD;
            state_q  <= ST_DONE;
          end else if (skew_on && too_new) begin
            result_q <= VERDICT_TOO_NEW;
            state_q  <= ST_DONE;
          end else begin
            state_q <= ST_PRUNE;
          end
        end
        ST_PRUNE: begin
          if (expired) begin
            count_q <= count_q - CW'(1);
          end else begin
            state_q <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          // Match flags were taken from the row as it stood after pruning.
          if (any_match) begin
            result_q <= VERDICT_DUPLICATE;
            state_q  <= ST_DONE;
          end else begin
            state_q <= ST_EVICT;
          end
        end
        ST_EVICT: begin
          if (count_q >= limit) begin
            count_q <= count_q - CW'(1);
          end else begin
            count_q  <= count_q + CW'(1);
            result_q <= VERDICT_OK;
            state_q  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            verdict_q   <= result_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/rwf_cell.sv */
// One storage cell of the replay window filter: holds one id and its time,
// hands them on towards the oldest end, and compares its id with the key.
// Depends on rwf_pkg.
module rwf_cell
  import rwf_pkg::*;
(
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [ID_W-1:0]   next_id_i,
  input  logic [TIME_W-1:0] next_time_i,
  input  logic [ID_W-1:0]   key_id_i,
  input  logic [TIME_W-1:0] key_time_i,
  output logic [ID_W-1:0]   id_o,
  output logic [TIME_W-1:0] time_o,
  output logic              match_o
);

  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] time_q;
  logic              match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      id_q   <= key_id_i;
      time_q <= key_time_i;
    end else if (ctrl_i.shift) begin
      id_q   <= next_id_i;
      time_q <= next_time_i;
    end
    match_q <= (id_q == key_id_i);
  end

  assign id_o    = id_q;
  assign time_o  = time_q;
  assign match_o = match_q;

endmodule
